FILE: hw/rtl/csfw_pkg.sv
// shared types, codes and sizes for the counting semaphore with waiter queue
package csfw_pkg;

	localparam int MAX_WAITERS    = 16;
	localparam int THREAD_ID_BITS = 8;
	localparam int QIDX_W         = (MAX_WAITERS > 1) ? $clog2(MAX_WAITERS) : 1;
	localparam int FILL_W         = $clog2(MAX_WAITERS + 1);
	localparam int CNT_W          = 16;
	localparam int INIT_W         = 15;
	localparam int ACT_W          = 3;
	localparam int STATUS_W       = 3;

	// request actions
	localparam logic [ACT_W-1:0] ACT_WAIT    = 3'd0;
	localparam logic [ACT_W-1:0] ACT_SIGNAL  = 3'd1;
	localparam logic [ACT_W-1:0] ACT_TRYWAIT = 3'd2;
	localparam logic [ACT_W-1:0] ACT_CLOSE   = 3'd3;
	localparam logic [ACT_W-1:0] ACT_OPEN    = 3'd4;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_OK          = 3'd0;
	localparam logic [STATUS_W-1:0] ST_BLOCKED     = 3'd1;
	localparam logic [STATUS_W-1:0] ST_WOULD_BLOCK = 3'd2;
	localparam logic [STATUS_W-1:0] ST_CLOSED      = 3'd3;
	localparam logic [STATUS_W-1:0] ST_QUEUE_FULL  = 3'd4;
	localparam logic [STATUS_W-1:0] ST_OVERFLOW    = 3'd5;

	localparam logic signed [CNT_W-1:0] COUNT_MAX = 16'sd32767;

	// controller to datapath
	typedef struct packed {
		logic load_item;
		logic exec;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic out_free;
		logic drain_more;
	} dp_sts_t;

endpackage

FILE: hw/rtl/counting_semaphore_fifo_waiters_top.sv
// top level of the counting semaphore with a first-in first-out queue of waiters
//
// Counting semaphore with up to 16 queued waiters. Each request on the slave stream
// carries an action (wait, signal, trywait, close, open) and the caller's thread id;
// every request gives one result on the master stream, except close, which gives one
// result per queued waiter (oldest first, status closed, tuser high, tlast low) and a
// final ok result with tlast high. A request is captured in the idle state, and the
// execute state updates the count, the queue pointers and the output register.
// A close releases one queued waiter per execute or drain step, since the queue
// memory has a single registered read port, read ahead at the next head each cycle.
// Downstream back-pressure holds the result in the output register and stalls the
// controller in execute or drain; the request port is ready only between requests.
// The initial count is written on the cfg channel, which is always ready; it takes
// effect at the next open. The count starts at zero and the semaphore starts closed.
module counting_semaphore_fifo_waiters_top (
	input  logic        clk,
	input  logic        arst_n,
	// request stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [2:0] action, [10:3] thread_id, [15:11] zero
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [2:0] status, [10:3] woken_thread, [15:11] zero
	output logic [0:0]  m_tuser,   // [0] woken_valid
	output logic        m_tlast,   // last result of the request
	// initial count register
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [14:0] cfg_data
);
	import csfw_pkg::*;

	dp_cmd_t                   cmd;
	dp_sts_t                   sts;
	logic [STATUS_W-1:0]       res_status;
	logic                      res_woken;
	logic [THREAD_ID_BITS-1:0] res_thread;

	// register writes are always taken
	assign cfg_ready = 1'b1;

	csfw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	csfw_dp u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_valid        (cfg_valid),
		.cfg_data         (cfg_data),
		.in_action        (s_tdata[ACT_W-1:0]),
		.in_thread        (s_tdata[ACT_W+THREAD_ID_BITS-1:ACT_W]),
		.cmd              (cmd),
		.sts              (sts),
		.out_ready        (m_tready),
		.out_valid        (m_tvalid),
		.out_status       (res_status),
		.out_woken_valid  (res_woken),
		.out_woken_thread (res_thread),
		.out_last         (m_tlast)
	);

	// pack the result, zero fill up to whole bytes
	assign m_tdata = {5'b0, res_thread, res_status};
	assign m_tuser = res_woken;

endmodule

FILE: hw/rtl/csfw_ctrl.sv
// controller state machine: take a request, execute it, drain the queue on close
module csfw_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  csfw_pkg::dp_sts_t sts,
	output csfw_pkg::dp_cmd_t cmd
);
	import csfw_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE  = 3'b001,
		S_EXEC  = 3'b010,
		S_DRAIN = 3'b100
	} state_t;

	state_t state_q, state_d;

	assign s_tready = (state_q == S_IDLE);

	always_comb begin
		state_d       = state_q;
		cmd.load_item = 1'b0;
		cmd.exec      = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					cmd.load_item = 1'b1;
					state_d       = S_EXEC;
				end
			end
			S_EXEC, S_DRAIN: begin
				if (sts.out_free) begin
					cmd.exec = 1'b1;
					state_d  = sts.drain_more ? S_DRAIN : S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

FILE: hw/rtl/csfw_dp.sv
// datapath: count, open flag, waiter queue and output register
module csfw_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	input  logic [csfw_pkg::INIT_W-1:0]         cfg_data,
	input  logic [csfw_pkg::ACT_W-1:0]          in_action,
	input  logic [csfw_pkg::THREAD_ID_BITS-1:0] in_thread,
	input  csfw_pkg::dp_cmd_t                   cmd,
	output csfw_pkg::dp_sts_t                   sts,
	input  logic                                out_ready,
	output logic                                out_valid,
	output logic [csfw_pkg::STATUS_W-1:0]       out_status,
	output logic                                out_woken_valid,
	output logic [csfw_pkg::THREAD_ID_BITS-1:0] out_woken_thread,
	output logic                                out_last
);
	import csfw_pkg::*;

	function automatic logic [QIDX_W-1:0] next_slot(input logic [QIDX_W-1:0] i);
		if (i == QIDX_W'(MAX_WAITERS - 1)) begin
			return '0;
		end
		return i + QIDX_W'(1);
	endfunction

	logic [INIT_W-1:0]          init_count_q;
	logic [ACT_W-1:0]           action_q;
	logic [THREAD_ID_BITS-1:0]  thread_q;
	logic signed [CNT_W-1:0]    count_q, count_d, count_inc;
	logic                       open_q, open_d;
	logic [QIDX_W-1:0]          head_q, tail_q, rd_addr;
	logic [FILL_W-1:0]          fill_q;
	logic [THREAD_ID_BITS-1:0]  queue_q [MAX_WAITERS];
	logic [THREAD_ID_BITS-1:0]  head_data_q;
	logic                       push, pop, fire;
	logic                       fill_nz, fill_full;
	logic [STATUS_W-1:0]        res_status;
	logic                       res_woken, res_last;

	logic                       out_valid_q;
	logic [STATUS_W-1:0]        out_status_q;
	logic                       out_woken_q;
	logic [THREAD_ID_BITS-1:0]  out_thread_q;
	logic                       out_last_q;

	assign fire       = cmd.exec && sts.out_free;
	assign fill_nz    = (fill_q != '0);
	assign fill_full  = (fill_q == FILL_W'(MAX_WAITERS));
	assign count_inc  = count_q + 16'sd1;

	assign sts.out_free   = !out_valid_q || out_ready;
	assign sts.drain_more = (action_q == ACT_CLOSE) && fill_nz;

	// one request's effect on count, flag and queue
	always_comb begin
		count_d    = count_q;
		open_d     = open_q;
		push       = 1'b0;
		pop        = 1'b0;
		res_status = ST_OK;
		res_woken  = 1'b0;
		res_last   = 1'b1;
		case (action_q)
			ACT_WAIT: begin
				if (!open_q) begin
					res_status = ST_CLOSED;
				end else if (count_q > 16'sd0) begin
					count_d = count_q - 16'sd1;
				end else if (fill_full) begin
					res_status = ST_QUEUE_FULL;
				end else begin
					count_d    = count_q - 16'sd1;
					push       = 1'b1;
					res_status = ST_BLOCKED;
				end
			end
			ACT_SIGNAL: begin
				if (!open_q) begin
					res_status = ST_CLOSED;
				end else if (count_q >= COUNT_MAX) begin
					res_status = ST_OVERFLOW;
				end else begin
					count_d = count_inc;
					if (count_inc <= 16'sd0 && fill_nz) begin
						pop       = 1'b1;
						res_woken = 1'b1;
					end
				end
			end
			ACT_TRYWAIT: begin
				if (!open_q) begin
					res_status = ST_CLOSED;
				end else if (count_q > 16'sd0) begin
					count_d = count_q - 16'sd1;
				end else begin
					res_status = ST_WOULD_BLOCK;
				end
			end
			ACT_CLOSE: begin
				open_d = 1'b0;
				if (fill_nz) begin
					pop        = 1'b1;
					res_status = ST_CLOSED;
					res_woken  = 1'b1;
					res_last   = 1'b0;
				end
			end
			ACT_OPEN: begin
				count_d = CNT_W'(init_count_q);
				open_d  = 1'b1;
			end
			default: ;
		endcase
	end

	// read ahead at the head that will stand after this cycle
	assign rd_addr = (fire && pop) ? next_slot(head_q) : head_q;

	always_ff @(posedge clk) begin
		if (fire && push) begin
			queue_q[tail_q] <= thread_q;
		end
		head_data_q <= queue_q[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			action_q <= in_action;
			thread_q <= in_thread;
		end
		if (fire) begin
			out_status_q <= res_status;
			out_woken_q  <= res_woken;
			out_thread_q <= res_woken ? head_data_q : '0;
			out_last_q   <= res_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_count_q <= '0;
			count_q      <= '0;
			open_q       <= 1'b0;
			head_q       <= '0;
			tail_q       <= '0;
			fill_q       <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_valid) begin
				init_count_q <= cfg_data;
			end
			if (fire) begin
				count_q     <= count_d;
				open_q      <= open_d;
				out_valid_q <= 1'b1;
				if (push) begin
					tail_q <= next_slot(tail_q);
					fill_q <= fill_q + FILL_W'(1);
				end
				if (pop) begin
					head_q <= next_slot(head_q);
					fill_q <= fill_q - FILL_W'(1);
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid        = out_valid_q;
	assign out_status       = out_status_q;
	assign out_woken_valid  = out_woken_q;
	assign out_woken_thread = out_thread_q;
	assign out_last         = out_last_q;

endmodule

FILE: hw/rtl/csfw_checker.sv
// port-level checks for the semaphore top, bound to it
module csfw_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata,
	input logic [0:0]  m_tuser,
	input logic        m_tlast
);
	import csfw_pkg::*;

	// a held result keeps its payload
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast))
		else $error("result changed while stalled");

	// one request at a time
	a_one_req: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request port ready right after a request");

	// a released waiter is reported only as ok or closed
	a_woken_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> (m_tdata[2:0] == ST_OK) || (m_tdata[2:0] == ST_CLOSED))
		else $error("woken waiter with wrong status");

	// only close drain results are not last
	a_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> m_tuser[0] && (m_tdata[2:0] == ST_CLOSED))
		else $error("non-final result outside a close");

endmodule

bind counting_semaphore_fifo_waiters_top csfw_checker u_csfw_checker (.*);
